// ===== rtl/core/rrs_pkg.sv =====
`default_nettype none

package rrs_pkg;

  // Default sizing
  localparam int unsigned MAX_PROCESSES_DEFAULT = 8;
  localparam int unsigned BURST_BITS_DEFAULT    = 16;
  localparam int unsigned WAIT_BITS_DEFAULT     = 32;

  // Fixed field widths
  localparam int unsigned BurstFieldW = 16;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned SlotFieldW  = 3;
  localparam int unsigned WaitFieldW  = 32;
  localparam int unsigned CountFieldW = 4;

  // Operation codes
  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] STATUS_OK         = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL       = 2'd2;
  localparam logic [StatusW-1:0] STATUS_ZERO_BURST = 2'd3;

  typedef struct packed {
    logic                   operation;
    logic [BurstFieldW-1:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0]     status;
    logic [SlotFieldW-1:0]  process_slot;
    logic                   process_finished;
    logic [WaitFieldW-1:0]  process_wait;
    logic [WaitFieldW-1:0]  total_wait;
    logic [CountFieldW-1:0] admitted_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrs_if.sv =====
`default_nettype none

interface rrs_in_if;
  logic               valid;
  logic               ready;
  rrs_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rrs_out_if;
  logic               valid;
  logic               ready;
  rrs_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/round_robin_scheduler_wait_tracker_top.sv =====
`default_nettype none
// Round-robin scheduler, quantum of one tick, with per-process wait tracking.
// Path: admit, rejected and empty-tick items go from accept straight to exec; served ticks
//   first pass ring read, record read and delta, then update/write-back into the output reg.
// One transaction in flight, stepped through the sequencer phases; the next is accepted
//   while a result waits in the output reg.
// Reset: async, active low; clears counters, ring pointers and FSM, not the memories.

module round_robin_scheduler_wait_tracker_top #(
  parameter int unsigned MAX_PROCESSES = rrs_pkg::MAX_PROCESSES_DEFAULT,
  parameter int unsigned BURST_BITS    = rrs_pkg::BURST_BITS_DEFAULT,
  parameter int unsigned WAIT_BITS     = rrs_pkg::WAIT_BITS_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrs_in_if.sink    in_i,
  rrs_out_if.source out_o
);

  localparam int unsigned SlotW = $clog2(MAX_PROCESSES);
  localparam int unsigned CntW  = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned PosW  = SlotW + 1;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_PROCESSES - 1);
  localparam logic [CntW-1:0]  MaxCnt   = CntW'(MAX_PROCESSES);
  localparam logic [PosW-1:0]  MaxPos   = PosW'(MAX_PROCESSES);
  localparam logic [WAIT_BITS-1:0] WaitMax = '1;

  // Per-process record held in one memory word
  typedef struct packed {
    logic [BURST_BITS-1:0] remaining;
    logic [WAIT_BITS-1:0]  wait_sum;
    logic [WAIT_BITS-1:0]  last_served;
  } record_t;

  // One-hot sequencer
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_DELTA = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Control state
  logic [SlotW-1:0]     head_q, head_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      admit_q, admit_d;
  logic [WAIT_BITS-1:0] tick_q, tick_d;
  logic [WAIT_BITS-1:0] grand_q, grand_d;

  // Latched transaction
  logic                  op_q;
  logic [BURST_BITS-1:0] burst_q;

  // Memories and their registered read data
  logic [SlotW-1:0] ring_mem [MAX_PROCESSES];
  record_t          rec_mem  [MAX_PROCESSES];
  logic [SlotW-1:0] ring_rd_q;
  record_t          rec_rd_q;
  logic [SlotW-1:0] slot_q;
  logic [WAIT_BITS-1:0] delta_q;

  // Output register
  logic               out_valid_q;
  rrs_pkg::out_item_t out_q, out_d;

  logic in_fire, out_free, exec_go;
  logic [SlotW-1:0] fetch_slot;
  logic [PosW-1:0]  tail_sum;
  logic [SlotW-1:0] tail_pos;

  logic             ring_we;
  logic [SlotW-1:0] ring_wslot;
  logic             rec_we;
  logic [SlotW-1:0] rec_waddr;
  record_t          rec_wdata;

  // Tick arithmetic
  logic [WAIT_BITS:0]    wsum_ext, gsum_ext;
  logic [WAIT_BITS-1:0]  wsum_sat, gsum_sat, tick_next;
  logic [BURST_BITS-1:0] rem_next;
  logic                  fin;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_free      = !out_valid_q || out_o.ready;
  assign exec_go       = (state_q == ST_EXEC) && out_free;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Slot index from the ring; out-of-range codes fall back to slot zero
  assign fetch_slot = (ring_rd_q > LastSlot) ? '0 : ring_rd_q;

  // Tail of the ring: head + count, wrapped once
  assign tail_sum = PosW'(head_q) + PosW'(count_q);
  assign tail_pos = (tail_sum >= MaxPos) ? SlotW'(tail_sum - MaxPos) : SlotW'(tail_sum);

  // Served process update
  assign wsum_ext  = {1'b0, rec_rd_q.wait_sum} + {1'b0, delta_q};
  assign gsum_ext  = {1'b0, grand_q} + {1'b0, delta_q};
  assign wsum_sat  = wsum_ext[WAIT_BITS] ? WaitMax : wsum_ext[WAIT_BITS-1:0];
  assign gsum_sat  = gsum_ext[WAIT_BITS] ? WaitMax : gsum_ext[WAIT_BITS-1:0];
  assign rem_next  = (rec_rd_q.remaining != '0) ? rec_rd_q.remaining - 1'b1
                                                : rec_rd_q.remaining;
  assign fin       = (rem_next == '0);
  assign tick_next = tick_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    admit_d    = admit_q;
    tick_d     = tick_q;
    grand_d    = grand_q;
    out_d      = out_q;
    ring_we    = 1'b0;
    ring_wslot = slot_q;
    rec_we     = 1'b0;
    rec_waddr  = slot_q;
    rec_wdata  = rec_rd_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // Ticks with work queued need the ring and record reads
          if (in_i.payload.operation == rrs_pkg::OP_TICK && count_q != '0) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_DELTA;
      end
      ST_DELTA: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d                  = ST_IDLE;
          out_d.status             = rrs_pkg::STATUS_OK;
          out_d.process_slot       = '0;
          out_d.process_finished   = 1'b0;
          out_d.process_wait       = '0;
          if (op_q == rrs_pkg::OP_ADMIT) begin
            if (burst_q == '0) begin
              out_d.status = rrs_pkg::STATUS_ZERO_BURST;
            end else if (admit_q >= MaxCnt || count_q >= MaxCnt) begin
              out_d.status = rrs_pkg::STATUS_FULL;
            end else begin
              // New process at the tail, stamped with the current tick
              rec_we                = 1'b1;
              rec_waddr             = SlotW'(admit_q);
              rec_wdata.remaining   = burst_q;
              rec_wdata.wait_sum    = '0;
              rec_wdata.last_served = tick_q;
              ring_we               = 1'b1;
              ring_wslot            = SlotW'(admit_q);
              count_d               = count_q + 1'b1;
              admit_d               = admit_q + 1'b1;
              out_d.process_slot    = rrs_pkg::SlotFieldW'(admit_q);
            end
          end else if (count_q == '0) begin
            out_d.status = rrs_pkg::STATUS_EMPTY;
          end else begin
            // Serve head; requeue at tail (head+count) if work remains
            rec_we                 = 1'b1;
            rec_waddr              = slot_q;
            rec_wdata.remaining    = rem_next;
            rec_wdata.wait_sum     = wsum_sat;
            rec_wdata.last_served  = tick_next;
            ring_we                = !fin;
            ring_wslot             = slot_q;
            head_d                 = (head_q == LastSlot) ? '0 : head_q + 1'b1;
            count_d                = fin ? count_q - 1'b1 : count_q;
            tick_d                 = tick_next;
            grand_d                = gsum_sat;
            out_d.process_slot     = rrs_pkg::SlotFieldW'(slot_q);
            out_d.process_finished = fin;
            out_d.process_wait     = rrs_pkg::WaitFieldW'(wsum_sat);
          end
          out_d.total_wait     = rrs_pkg::WaitFieldW'(grand_d);
          out_d.admitted_count = rrs_pkg::CountFieldW'(admit_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      admit_q     <= '0;
      tick_q      <= '0;
      grand_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      admit_q <= admit_d;
      tick_q  <= tick_d;
      grand_q <= grand_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_fire) begin
      op_q    <= in_i.payload.operation;
      burst_q <= BURST_BITS'(in_i.payload.burst_length);
    end
    if (state_q == ST_FETCH) begin
      slot_q <= fetch_slot;
    end
    if (state_q == ST_DELTA) begin
      // Ticks since the process last ran, modulo the counter width
      delta_q <= tick_q - rec_rd_q.last_served;
    end
  end

  // Ring memory: read at head on accept, written at tail on admit/requeue
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring_rd_q <= ring_mem[head_q];
    end
    if (ring_we) begin
      ring_mem[tail_pos] <= ring_wslot;
    end
  end

  // Record memory: read during fetch, written back at the end of the item
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH) begin
      rec_rd_q <= rec_mem[fetch_slot];
    end
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== bench/round_robin_scheduler_wait_tracker_top_test.sv =====
`default_nettype none

module round_robin_scheduler_wait_tracker_top_test;
  import rrs_pkg::*;

  localparam int unsigned NUM_SLOTS     = MAX_PROCESSES_DEFAULT;
  localparam int unsigned RANDOM_ITEMS  = 900;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int unsigned HOLD_CYCLES   = 300;
  // Settle time after the last result.
  localparam int unsigned DRAIN_CYCLES  = 20;
  // Timeout in time units, set well beyond a run of roughly 920 items
  // plus the hold-off.
  localparam int unsigned TIMEOUT_UNITS = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #2 clk_i = ~clk_i;

  rrs_in_if  in_bus ();
  rrs_out_if out_bus ();

  round_robin_scheduler_wait_tracker_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Transactions waiting to be driven, and results still owed by the block.
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int unsigned accepted_count    = 0;
  int unsigned total_items       = 0;
  int unsigned error_count       = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_off          = 1'b0;

  // ---------------------------------------------------------------------------
  // Scheduler state as the block should hold it.
  // The ready ring keeps slots in service order: head points at the next
  // process to run, and a process that still has work goes back to the tail.
  // Waiting is tracked with timestamps: each process remembers the tick count
  // at which it last stopped running (or was admitted).
  // ---------------------------------------------------------------------------
  logic [SlotFieldW-1:0]  sched_ring[NUM_SLOTS];
  int unsigned            sched_head  = 0;
  int unsigned            sched_count = 0;
  logic [BurstFieldW-1:0] work_left[NUM_SLOTS];
  logic [WaitFieldW-1:0]  slot_wait[NUM_SLOTS];
  logic [WaitFieldW-1:0]  last_run_tick[NUM_SLOTS];
  logic [WaitFieldW-1:0]  tick_count  = '0;
  logic [WaitFieldW-1:0]  grand_wait  = '0;
  int unsigned            admit_count = 0;

  function automatic logic [WaitFieldW-1:0] wait_add_sat(logic [WaitFieldW-1:0] a,
                                                         logic [WaitFieldW-1:0] b);
    logic [WaitFieldW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[WaitFieldW] ? '1 : sum[WaitFieldW-1:0];
  endfunction

  // Advance the scheduler by one transaction and queue the result it owes.
  task automatic predict_schedule_result(in_item_t item);
    out_item_t             res;
    int unsigned           slot;
    logic [WaitFieldW-1:0] delta;
    res = '0;
    if (item.operation == OP_ADMIT) begin
      if (item.burst_length == '0) begin
        // zero burst is rejected before the full check
        res.status = STATUS_ZERO_BURST;
      end else if (admit_count >= NUM_SLOTS || sched_count >= NUM_SLOTS) begin
        // slots are never reused, so after the table fills every admit fails
        res.status = STATUS_FULL;
      end else begin
        slot = admit_count;
        admit_count++;
        work_left[slot]     = item.burst_length;
        slot_wait[slot]     = '0;
        last_run_tick[slot] = tick_count;
        sched_ring[(sched_head + sched_count) % NUM_SLOTS] = SlotFieldW'(slot);
        sched_count++;
        res.status       = STATUS_OK;
        res.process_slot = SlotFieldW'(slot);
      end
    end else if (sched_count == 0) begin
      // empty tick: nothing moves, tick count does not advance
      res.status = STATUS_EMPTY;
    end else begin
      slot        = int'(sched_ring[sched_head]);
      sched_head  = (sched_head + 1) % NUM_SLOTS;
      sched_count--;
      delta           = tick_count - last_run_tick[slot];
      slot_wait[slot] = wait_add_sat(slot_wait[slot], delta);
      grand_wait      = wait_add_sat(grand_wait, delta);
      if (work_left[slot] != '0) work_left[slot]--;
      tick_count          = tick_count + 1;
      last_run_tick[slot] = tick_count;
      if (work_left[slot] != '0) begin
        sched_ring[(sched_head + sched_count) % NUM_SLOTS] = SlotFieldW'(slot);
        sched_count++;
      end
      res.status           = STATUS_OK;
      res.process_slot     = SlotFieldW'(slot);
      res.process_finished = (work_left[slot] == '0);
      res.process_wait     = slot_wait[slot];
    end
    res.total_wait     = grand_wait;
    res.admitted_count = CountFieldW'(admit_count);
    expected_results.push_back(res);
  endtask

  function automatic bit field_matches(string name, longint unsigned exp_val,
                                       longint unsigned act_val);
    if (exp_val == act_val) return 1'b1;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
    return 1'b0;
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t exp;
    bit        ok;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %p", $time, got);
      error_count++;
      return;
    end
    exp = expected_results.pop_front();
    ok  = 1'b1;
    ok &= field_matches("status", exp.status, got.status);
    ok &= field_matches("process_slot", exp.process_slot, got.process_slot);
    ok &= field_matches("process_finished", exp.process_finished, got.process_finished);
    ok &= field_matches("process_wait", exp.process_wait, got.process_wait);
    ok &= field_matches("total_wait", exp.total_wait, got.total_wait);
    ok &= field_matches("admitted_count", exp.admitted_count, got.admitted_count);
    if (!ok) error_count++;
  endtask

  task automatic queue_item(logic op, logic [BurstFieldW-1:0] burst);
    in_item_t item;
    item.operation    = op;
    item.burst_length = burst;
    pending_items.push_back(item);
    total_items++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending transaction when the slot is free, unless an idle draw holds it back.
  // The accepted transaction is fed to the predictor at the edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.payload <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_schedule_result(in_bus.payload);
        accepted_count <= accepted_count + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_bus.valid   <= 1'b1;
          in_bus.payload <= pending_items.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result and decides ready for the next edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_result(out_bus.payload);
      out_bus.ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the block's
  // output register fills and it must stall its input.
  initial begin
    wait (accepted_count >= 800);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #TIMEOUT_UNITS;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, idle phases and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned           pick;
    logic [BurstFieldW-1:0] burst;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;

    // Directed: empty tick, zero burst, a one-tick process that finishes at
    // once, empty tick again, then a mix including the largest burst so the
    // ring rotates through several processes with growing waits.
    queue_item(OP_TICK,  16'h0000);
    queue_item(OP_ADMIT, 16'h0000);
    queue_item(OP_ADMIT, 16'h0001);
    queue_item(OP_TICK,  16'hFFFF);
    queue_item(OP_TICK,  16'h0000);
    queue_item(OP_ADMIT, 16'hFFFF);
    queue_item(OP_ADMIT, 16'h0002);
    queue_item(OP_ADMIT, 16'h0003);
    repeat (7) queue_item(OP_TICK, 16'h5A5A);

    // Random: mostly ticks to keep the ring turning; admits use up the
    // remaining slots early, after which they hit the full and zero checks.
    // Burst bits on ticks are random too, since the block must ignore them.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 10)      burst = '0;
      else if (pick < 70) burst = BurstFieldW'($urandom_range(12, 1));
      else                burst = BurstFieldW'($urandom_range(16'hFFFF));
      if ($urandom_range(99) < 20) queue_item(OP_ADMIT, burst);
      else                         queue_item(OP_TICK, BurstFieldW'($urandom_range(16'hFFFF)));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle phases, switched on progress through the stream
    wait (accepted_count >= 250);
    sender_idle_pct    <= 66;
    wait (accepted_count >= 450);
    sender_idle_pct    <= 0;
    receiver_stall_pct <= 66;
    wait (accepted_count >= 650);
    sender_idle_pct    <= 29;
    receiver_stall_pct <= 29;
    wait (accepted_count >= 800);
    sender_idle_pct    <= 0;
    receiver_stall_pct <= 0;

    wait (accepted_count == total_items);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
